[hdl/mtpl_pkg.sv]
package mtpl_pkg;

    localparam int NUM_TRACKS_DEF = 4;
    localparam int COORD_BITS_DEF = 10;
    localparam int SUM_W          = 32;
    localparam int FRAC_SHIFT     = 16;

    localparam logic [SUM_W-1:0] SUM_MAX = '1;

endpackage

[hdl/mtpl_in_if.sv]
interface mtpl_in_if #(
    parameter int TRACK_W = 2,
    parameter int COORD_W = 10
);
    logic               valid;
    logic               ready;
    logic [TRACK_W-1:0] track;
    logic [COORD_W-1:0] pos_x;
    logic [COORD_W-1:0] pos_y;
    logic               last_point;

    modport source (output valid, output track, output pos_x, output pos_y,
                    output last_point, input ready);
    modport sink   (input valid, input track, input pos_x, input pos_y,
                    input last_point, output ready);
endinterface

[hdl/mtpl_out_if.sv]
interface mtpl_out_if #(
    parameter int TRACK_W = 2,
    parameter int SUM_W   = 32
);
    logic               valid;
    logic               ready;
    logic [TRACK_W-1:0] out_track;
    logic [SUM_W-1:0]   total_length;
    logic               saturated;

    modport source (output valid, output out_track, output total_length,
                    output saturated, input ready);
    modport sink   (input valid, input out_track, input total_length,
                    input saturated, output ready);
endinterface

[hdl/mtpl_sqrt.sv]
module mtpl_sqrt #(
    parameter int ROOT_W = mtpl_pkg::COORD_BITS_DEF + 9
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [2*ROOT_W-1:0] i_radicand,
    output logic                o_done,
    output logic [ROOT_W-1:0]   o_root
);
    import mtpl_pkg::*;

    localparam int RAD_W = 2 * ROOT_W;
    localparam int REM_W = ROOT_W + 2;
    localparam int CNT_W = $clog2(ROOT_W + 1);

    logic [RAD_W-1:0]  r_rad;
    logic [REM_W-1:0]  r_rem;
    logic [ROOT_W-1:0] r_root;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_done;

    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    logic             fits;

    // One result bit per cycle: bring down two radicand bits and try 4*root+1.
    assign rem_sh = {r_rem[REM_W-3:0], r_rad[RAD_W-1 -: 2]};
    assign trial  = {r_root, 2'b01};
    assign fits   = (rem_sh >= trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= CNT_W'(ROOT_W);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_radicand;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_cnt != '0) begin
            r_rad  <= {r_rad[RAD_W-3:0], 2'b00};
            r_rem  <= fits ? (rem_sh - trial) : rem_sh;
            r_root <= {r_root[ROOT_W-2:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

[hdl/multi_track_path_length_unit.sv]
// Path length accumulator for several interleaved tracks.
// Input channel i_in carries one position word: track number, x, y and a
// last-point flag. Output channel o_out carries one result word per sample
// flagged last with a track number below NUM_TRACKS: the track number, its
// total length (unsigned, 8 fraction bits, clipped at all ones) and a flag
// telling whether clipping occurred. Both channels use valid/ready; a word
// moves when both are high. A sample that extends a track passes through the
// difference, the squares of dx and dy, the bit-serial square root (one root
// bit per cycle) and the update; the first point of a track skips from the
// difference to the update; a sample for any other track number is dropped.
// A total becomes valid on o_out at the same edge that raises ready again.
// The result sits in an output register, so the next sample is accepted while
// an earlier total waits to be taken; a second last-flagged sample holds in
// its final step until that register is free.
// Synchronous active-low reset clears every track (no previous point, zero
// sum, no clipping) and empties the output register.
module multi_track_path_length_unit #(
    parameter int NUM_TRACKS = mtpl_pkg::NUM_TRACKS_DEF,
    parameter int COORD_BITS = mtpl_pkg::COORD_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mtpl_in_if.sink     i_in,
    mtpl_out_if.source  o_out
);
    import mtpl_pkg::*;

    localparam int TRACK_W = (NUM_TRACKS > 1) ? $clog2(NUM_TRACKS) : 1;
    localparam int ROOT_W  = COORD_BITS + 9;
    localparam int SQ_W    = 2 * COORD_BITS + 1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIFF = 3'd1;
    localparam logic [2:0] S_MULX = 3'd2;
    localparam logic [2:0] S_MULY = 3'd3;
    localparam logic [2:0] S_SQST = 3'd4;
    localparam logic [2:0] S_ROOT = 3'd5;
    localparam logic [2:0] S_UPD  = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    logic [TRACK_W-1:0]    r_trk;
    logic [COORD_BITS-1:0] r_x;
    logic [COORD_BITS-1:0] r_y;
    logic                  r_last;
    logic                  r_hp;
    logic [COORD_BITS-1:0] r_dx;
    logic [COORD_BITS-1:0] r_dy;
    logic [SQ_W-1:0]       r_sq;

    logic [COORD_BITS-1:0] r_px   [NUM_TRACKS];
    logic [COORD_BITS-1:0] r_py   [NUM_TRACKS];
    logic                  r_tvld [NUM_TRACKS];
    logic [SUM_W-1:0]      r_sum  [NUM_TRACKS];
    logic                  r_sat  [NUM_TRACKS];

    logic               r_ov;
    logic [TRACK_W-1:0] r_otrk;
    logic [SUM_W-1:0]   r_otot;
    logic               r_osat;

    logic                    in_acc;
    logic                    trk_ok;
    logic [COORD_BITS-1:0]   cur_px;
    logic [COORD_BITS-1:0]   cur_py;
    logic [COORD_BITS-1:0]   mul_op;
    logic [2*COORD_BITS-1:0] mul_out;
    logic                    sq_start;
    logic                    sq_done;
    logic [ROOT_W-1:0]       seg;
    logic [SUM_W:0]          sum_wide;
    logic                    ovf;
    logic [SUM_W-1:0]        new_sum;
    logic                    new_sat;
    logic                    out_free;
    logic                    upd_go;

    assign in_acc  = i_in.valid && i_in.ready;
    assign trk_ok  = (32'(r_trk) < NUM_TRACKS);
    assign cur_px  = r_px[r_trk];
    assign cur_py  = r_py[r_trk];

    assign mul_op  = (r_state == S_MULX) ? r_dx : r_dy;
    assign mul_out = mul_op * mul_op;

    assign sq_start = (r_state == S_SQST);

    mtpl_sqrt #(
        .ROOT_W (ROOT_W)
    ) u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (sq_start),
        .i_radicand ({{(2*ROOT_W-SQ_W-FRAC_SHIFT){1'b0}}, r_sq, {FRAC_SHIFT{1'b0}}}),
        .o_done     (sq_done),
        .o_root     (seg)
    );

    assign sum_wide = {1'b0, r_sum[r_trk]} + (r_hp ? (SUM_W+1)'(seg) : '0);
    assign ovf      = sum_wide[SUM_W];
    assign new_sum  = ovf ? SUM_MAX : sum_wide[SUM_W-1:0];
    assign new_sat  = r_sat[r_trk] | ovf;
    assign out_free = !r_ov || o_out.ready;
    assign upd_go   = (r_state == S_UPD) && (!r_last || out_free);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_DIFF;
                end
            end
            S_DIFF: begin
                if (!trk_ok) begin
                    n_state = S_IDLE;
                end else if (r_tvld[r_trk]) begin
                    n_state = S_MULX;
                end else begin
                    n_state = S_UPD;
                end
            end
            S_MULX: n_state = S_MULY;
            S_MULY: n_state = S_SQST;
            S_SQST: n_state = S_ROOT;
            S_ROOT: begin
                if (sq_done) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                if (upd_go) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_trk  <= i_in.track;
            r_x    <= i_in.pos_x;
            r_y    <= i_in.pos_y;
            r_last <= i_in.last_point;
        end
        if (r_state == S_DIFF) begin
            r_hp <= r_tvld[r_trk];
            r_dx <= (r_x >= cur_px) ? (r_x - cur_px) : (cur_px - r_x);
            r_dy <= (r_y >= cur_py) ? (r_y - cur_py) : (cur_py - r_y);
        end
        if (r_state == S_MULX) begin
            r_sq <= SQ_W'(mul_out);
        end
        if (r_state == S_MULY) begin
            r_sq <= r_sq + SQ_W'(mul_out);
        end
    end

    always_ff @(posedge i_clk) begin
        if (upd_go) begin
            r_px[r_trk] <= r_x;
            r_py[r_trk] <= r_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_TRACKS; i++) begin
                r_tvld[i] <= 1'b0;
                r_sum[i]  <= '0;
                r_sat[i]  <= 1'b0;
            end
        end else if (upd_go) begin
            if (r_last) begin
                r_tvld[r_trk] <= 1'b0;
                r_sum[r_trk]  <= '0;
                r_sat[r_trk]  <= 1'b0;
            end else begin
                r_tvld[r_trk] <= 1'b1;
                r_sum[r_trk]  <= new_sum;
                r_sat[r_trk]  <= new_sat;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (upd_go && r_last) begin
            r_ov <= 1'b1;
        end else if (o_out.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (upd_go && r_last) begin
            r_otrk <= r_trk;
            r_otot <= new_sum;
            r_osat <= new_sat;
        end
    end

    assign i_in.ready         = (r_state == S_IDLE);
    assign o_out.valid        = r_ov;
    assign o_out.out_track    = r_otrk;
    assign o_out.total_length = r_otot;
    assign o_out.saturated    = r_osat;

endmodule

[hdl/mtpl_checker.sv]
module mtpl_checker #(
    parameter int TRACK_W = 2
) (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       i_in_ready,
    input logic                       i_out_valid,
    input logic                       i_out_ready,
    input logic [TRACK_W-1:0]         i_out_track,
    input logic [mtpl_pkg::SUM_W-1:0] i_out_total,
    input logic                       i_out_sat
);
    import mtpl_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("Output word dropped while stalled.");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable(i_out_track) && $stable(i_out_total) && $stable(i_out_sat))
        else $error("Output word changed while stalled.");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("Input ready while a sample is being processed.");

    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> !$past(i_in_ready))
        else $error("Result appeared without a sample in progress.");

endmodule

bind multi_track_path_length_unit mtpl_checker #(
    .TRACK_W (TRACK_W)
) u_mtpl_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_track (o_out.out_track),
    .i_out_total (o_out.total_length),
    .i_out_sat   (o_out.saturated)
);
